FILE: sv/sfd_pkg.sv
// Shared constants and types for the stereo feedback delay.
// Register map codes and gain limits; no dependencies.
`default_nettype none

package sfd_pkg;

   localparam int DLY_BITS  = 17;
   localparam int GAIN_BITS = 16;
   localparam int MIX_BITS  = 17;

   typedef logic [1:0] reg_index_type;

   localparam reg_index_type REG_DELAY    = 2'd0;
   localparam reg_index_type REG_FEEDBACK = 2'd1;
   localparam reg_index_type REG_MIX      = 2'd2;

   // 0.95 in Q0.16 and unity in Q1.16
   localparam logic [GAIN_BITS-1:0] FB_CAP = 16'd62259;
   localparam logic [MIX_BITS-1:0]  UNITY  = 17'd65536;

endpackage

`default_nettype wire

FILE: sv/stereo_feedback_delay_unit.sv
// Stereo feedback echo, top level: register port, delay memory, pipeline control.
// Uses sfd_pkg, sfd_ram and sfd_mac.
`default_nettype none

// Stereo feedback echo. Each word on req_ carries one left and one right
// Q1.15 sample; each word on rsp_ carries the mixed pair. A taken word passes
// stage 1, stage 2 and the output register before rsp_valid rises. The block
// takes one word per cycle while the output is not stalled; the only
// exception is a delay of exactly one sample, where the feedback path goes
// through the memory write and the next read, so no word is taken while the last
// one is in stage 1. Both channels share one delay memory (one read and one write
// per word); a word written at the same edge as a read of its entry reaches
// that read through a forwarding register. The memory is never cleared: a fill mark
// (write pointer plus a wrapped flag) makes entries not yet written read as
// zero, so the block is ready right after reset with no clearing pass.
// Registers (APB, byte address 4*i): 0 delay_length, 1 feedback_gain,
// 2 wet_mix. Delay or mix of zero passes input through and leaves the memory
// and write pointer alone. Change registers only while the block is idle.
module stereo_feedback_delay_unit #(
   parameter int DELAY_DEPTH = 131072,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // input words
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0] req_left_in,
   input  wire logic signed [SAMPLE_BITS-1:0] req_right_in,
   // result words
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed      [SAMPLE_BITS-1:0] rsp_left_out,
   output logic signed      [SAMPLE_BITS-1:0] rsp_right_out,
   // register port
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic        [3:0]             csr_paddr,
   input  wire logic        [31:0]            csr_pwdata,
   output logic             [31:0]            csr_prdata,
   output logic                               csr_pready
);

   localparam int AW = $clog2(DELAY_DEPTH);
   localparam int CW = (AW > sfd_pkg::DLY_BITS ? AW : sfd_pkg::DLY_BITS) + 1;
   localparam logic [CW-1:0] DMAX     = CW'(DELAY_DEPTH - 1);
   localparam logic [AW-1:0] LAST_POS = AW'(DELAY_DEPTH - 1);
   localparam logic [AW:0]   DEPTH_W  = (AW+1)'(DELAY_DEPTH);
   localparam logic [AW-1:0] ONE      = AW'(1);

   // ---------------------------------------------------------------- registers
   logic [sfd_pkg::DLY_BITS-1:0]  dly_ff;
   logic [sfd_pkg::GAIN_BITS-1:0] fbk_ff;
   logic [sfd_pkg::MIX_BITS-1:0]  mix_ff;
   sfd_pkg::reg_index_type        csr_idx;
   logic                          csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         dly_ff <= '0;
         fbk_ff <= '0;
         mix_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            sfd_pkg::REG_DELAY:    dly_ff <= csr_pwdata[sfd_pkg::DLY_BITS-1:0];
            sfd_pkg::REG_FEEDBACK: fbk_ff <= csr_pwdata[sfd_pkg::GAIN_BITS-1:0];
            sfd_pkg::REG_MIX:      mix_ff <= csr_pwdata[sfd_pkg::MIX_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         sfd_pkg::REG_DELAY:    csr_prdata = 32'(dly_ff);
         sfd_pkg::REG_FEEDBACK: csr_prdata = 32'(fbk_ff);
         sfd_pkg::REG_MIX:      csr_prdata = 32'(mix_ff);
         default:               csr_prdata = '0;
      endcase
   end

   // Clamp gains and delay to their usable ranges.
   logic [sfd_pkg::GAIN_BITS-1:0] fb_eff;
   logic [sfd_pkg::MIX_BITS-1:0]  wet_eff, dry_eff;
   logic [CW-1:0]                 dly_wide;
   logic [AW-1:0]                 d_eff;
   logic                          bypass;

   assign fb_eff   = (fbk_ff > sfd_pkg::FB_CAP) ? sfd_pkg::FB_CAP : fbk_ff;
   assign wet_eff  = (mix_ff > sfd_pkg::UNITY) ? sfd_pkg::UNITY : mix_ff;
   assign dry_eff  = sfd_pkg::UNITY - wet_eff;
   assign dly_wide = CW'(dly_ff);
   assign d_eff    = (dly_wide > DMAX) ? DMAX[AW-1:0] : dly_wide[AW-1:0];
   assign bypass   = (mix_ff == '0) || (dly_ff == '0);

   // ---------------------------------------------------------------- stage 0
   logic          adv, accept, hazard;
   logic [AW-1:0] wp_ff, wp_in, rd_addr;
   logic          wrapped_ff, wrapped_in, fill_ok;
   logic          s1_valid_ff, s1_bypass_ff, s1_fill_ff;
   logic [AW-1:0] s1_rd_ff, s1_wp_ff;
   logic signed [SAMPLE_BITS-1:0] s1_xl_ff, s1_xr_ff;
   logic          s2_valid_ff, s2_bypass_ff;
   logic [AW-1:0] s2_wp_ff;
   logic          rsp_valid_ff;

   // Advance the whole pipe whenever the output register can move.
   assign adv = !rsp_valid_ff || rsp_ready;

   // A one-sample delay needs the word in stage 1 written back before the
   // next read: hold the input while that word is in stage 1.
   assign hazard    = s1_valid_ff && !s1_bypass_ff && !bypass && (d_eff == ONE);
   assign req_ready = adv && !hazard;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (wp_ff >= d_eff) begin
         rd_addr = wp_ff - d_eff;
      end else begin
         rd_addr = AW'(({1'b0, wp_ff} + DEPTH_W) - {1'b0, d_eff});
      end
   end

   // Entry is written once the pointer has passed it or wrapped.
   assign fill_ok = wrapped_ff || (rd_addr < wp_ff);

   always_comb begin
      wp_in      = wp_ff;
      wrapped_in = wrapped_ff;
      if (accept && !bypass) begin
         if (wp_ff == LAST_POS) begin
            wp_in      = '0;
            wrapped_in = 1'b1;
         end else begin
            wp_in = wp_ff + ONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
      end
   end

   // ---------------------------------------------------------------- memory
   logic                         ram_we;
   logic [2*SAMPLE_BITS-1:0]     ram_wdata, ram_rdata;
   logic signed [SAMPLE_BITS-1:0] fbw_l, fbw_r, mixw_l, mixw_r, x2_l, x2_r;

   assign ram_we    = adv && s2_valid_ff && !s2_bypass_ff;
   assign ram_wdata = {fbw_l, fbw_r};

   sfd_ram #(
      .WIDTH (2*SAMPLE_BITS),
      .DEPTH (DELAY_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s2_wp_ff),
      .wr_data (ram_wdata),
      .rd_en   (adv),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // Last write, for a read issued at the same edge as that write.
   logic                     hist_valid_ff;
   logic [AW-1:0]            hist_addr_ff;
   logic [2*SAMPLE_BITS-1:0] hist_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_valid_ff <= 1'b0;
      end else if (ram_we) begin
         hist_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_we) begin
         hist_addr_ff <= s2_wp_ff;
         hist_data_ff <= ram_wdata;
      end
   end

   // ---------------------------------------------------------------- stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_bypass_ff <= bypass;
         s1_fill_ff   <= fill_ok;
         s1_rd_ff     <= rd_addr;
         s1_wp_ff     <= wp_ff;
         s1_xl_ff     <= req_left_in;
         s1_xr_ff     <= req_right_in;
      end
   end

   logic [2*SAMPLE_BITS-1:0]      y_pair;
   logic signed [SAMPLE_BITS-1:0] y_l, y_r;

   always_comb begin
      priority if (hist_valid_ff && (hist_addr_ff == s1_rd_ff)) begin
         y_pair = hist_data_ff;
      end else if (s1_fill_ff) begin
         y_pair = ram_rdata;
      end else begin
         y_pair = '0;
      end
   end

   assign y_l = y_pair[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign y_r = y_pair[SAMPLE_BITS-1:0];

   sfd_mac #(.SAMPLE_BITS(SAMPLE_BITS)) u_mac_left (
      .clock    (clock),
      .adv      (adv),
      .x_in     (s1_xl_ff),
      .y_in     (y_l),
      .fb       (fb_eff),
      .wet      (wet_eff),
      .dry      (dry_eff),
      .x_out    (x2_l),
      .fb_word  (fbw_l),
      .mix_word (mixw_l)
   );

   sfd_mac #(.SAMPLE_BITS(SAMPLE_BITS)) u_mac_right (
      .clock    (clock),
      .adv      (adv),
      .x_in     (s1_xr_ff),
      .y_in     (y_r),
      .fb       (fb_eff),
      .wet      (wet_eff),
      .dry      (dry_eff),
      .x_out    (x2_r),
      .fb_word  (fbw_r),
      .mix_word (mixw_r)
   );

   // ---------------------------------------------------------------- stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_bypass_ff <= s1_bypass_ff;
         s2_wp_ff     <= s1_wp_ff;
      end
   end

   // ---------------------------------------------------------------- output
   logic signed [SAMPLE_BITS-1:0] out_l_ff, out_r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_l_ff <= s2_bypass_ff ? x2_l : mixw_l;
         out_r_ff <= s2_bypass_ff ? x2_r : mixw_r;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = out_l_ff;
   assign rsp_right_out = out_r_ff;

endmodule

`default_nettype wire

FILE: sv/sfd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read during write to the same address returns the old data. No dependencies.
`default_nettype none

module sfd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: sv/sfd_mac.sv
// Per-channel arithmetic: registered products, then round and saturate
// for the feedback word and the mixed output word. Uses sfd_pkg.
`default_nettype none

module sfd_mac #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 adv,
   input  wire logic signed [SAMPLE_BITS-1:0]        x_in,
   input  wire logic signed [SAMPLE_BITS-1:0]        y_in,
   input  wire logic        [sfd_pkg::GAIN_BITS-1:0] fb,
   input  wire logic        [sfd_pkg::MIX_BITS-1:0]  wet,
   input  wire logic        [sfd_pkg::MIX_BITS-1:0]  dry,
   output logic signed      [SAMPLE_BITS-1:0]        x_out,
   output logic signed      [SAMPLE_BITS-1:0]        fb_word,
   output logic signed      [SAMPLE_BITS-1:0]        mix_word
);

   localparam int PW = SAMPLE_BITS + 18;
   localparam int SW = SAMPLE_BITS + 19;
   localparam int RW = SW - 16;
   localparam logic signed [RW-1:0] HI = {{(RW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [RW-1:0] LO = {{(RW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [SW-1:0] HALF = SW'(32768);

   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic signed [PW-1:0]          yfb_ff, xd_ff, yw_ff;
   logic signed [PW-1:0]          yfb_in, xd_in, yw_in;
   logic signed [17:0]            fb_s, wet_s, dry_s;
   logic signed [SW-1:0]          fb_sum, mix_sum;

   // floor((v + 2^15) / 2^16), then clamp to full scale
   function automatic logic signed [SAMPLE_BITS-1:0] round_sat(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] t;
      logic signed [RW-1:0] r;
      t = v + HALF;
      r = t[SW-1:16];
      if (r > HI) begin
         r = HI;
      end else if (r < LO) begin
         r = LO;
      end
      return r[SAMPLE_BITS-1:0];
   endfunction

   assign fb_s  = {2'b00, fb};
   assign wet_s = {1'b0, wet};
   assign dry_s = {1'b0, dry};

   assign yfb_in = y_in * fb_s;
   assign xd_in  = x_in * dry_s;
   assign yw_in  = y_in * wet_s;

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff   <= x_in;
         yfb_ff <= yfb_in;
         xd_ff  <= xd_in;
         yw_ff  <= yw_in;
      end
   end

   always_comb begin
      fb_sum  = ({{(SW-SAMPLE_BITS-16){x_ff[SAMPLE_BITS-1]}}, x_ff, 16'h0000})
                + SW'(yfb_ff);
      mix_sum = SW'(xd_ff) + SW'(yw_ff);
   end

   assign x_out    = x_ff;
   assign fb_word  = round_sat(fb_sum);
   assign mix_word = round_sat(mix_sum);

endmodule

`default_nettype wire

FILE: test/stereo_feedback_delay_unit_tb.sv
// Self-checking testbench for stereo_feedback_delay_unit: stereo feedback echo over
// valid/ready word channels with APB register setup. Depends on sfd_pkg and the RTL.
module stereo_feedback_delay_unit_tb;

   localparam int ECHO_DEPTH  = 131072;
   localparam int SAMPLE_W    = 16;
   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE      = 8;
   localparam int PHASES      = 12;
   localparam int PHASE_WORDS = 150;

   // register index with no register behind it
   localparam sfd_pkg::reg_index_type REG_UNUSED = 2'd3;

   typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
   } stereo_frame_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid    = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_left_in  = '0;
   logic signed [SAMPLE_W-1:0] req_right_in = '0;
   logic                       rsp_valid;
   logic                       rsp_ready    = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_left_out;
   logic signed [SAMPLE_W-1:0] rsp_right_out;
   logic                       csr_psel     = 1'b0;
   logic                       csr_penable  = 1'b0;
   logic                       csr_pwrite   = 1'b0;
   logic [3:0]                 csr_paddr    = '0;
   logic [31:0]                csr_pwdata   = '0;
   logic [31:0]                csr_prdata;
   logic                       csr_pready;

   stereo_feedback_delay_unit #(
      .DELAY_DEPTH(ECHO_DEPTH),
      .SAMPLE_BITS(SAMPLE_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_left_in(req_left_in),
      .req_right_in(req_right_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_left_out(rsp_left_out),
      .rsp_right_out(rsp_right_out),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Echo model: its own copy of the register settings, both delay
   // stores and the write pointer. The stores start at zero, which is
   // what the block returns for entries it has not written yet.
   // ------------------------------------------------------------------
   logic [sfd_pkg::DLY_BITS-1:0]  cfg_delay    = '0;
   logic [sfd_pkg::GAIN_BITS-1:0] cfg_feedback = '0;
   logic [sfd_pkg::MIX_BITS-1:0]  cfg_mix      = '0;
   int                   echo_wr_pos  = 0;
   bit signed [SAMPLE_W-1:0] left_echo  [0:ECHO_DEPTH-1];
   bit signed [SAMPLE_W-1:0] right_echo [0:ECHO_DEPTH-1];

   stereo_frame_type frames_to_send[$];   // words waiting for the driver
   stereo_frame_type mixed_due[$];        // predicted outputs, oldest first

   int mismatches = 0;

   // sender and receiver knobs, written only by the sequencing block; hold_done is set by the receiver
   int          gap_max  = 0;
   rx_mode_type rx_mode  = RX_ALWAYS;
   bit          hold_req = 1'b0;
   bit          hold_done;

   // Scale a Q.16 sum back to a sample: round half up, then clip to full scale.
   function automatic logic signed [SAMPLE_W-1:0] round_sat(input longint acc);
      longint r;
      r = (acc + 64'sd32768) >>> 16;
      if (r > 32767)
         r = 32767;
      else if (r < -32768)
         r = -32768;
      return r[SAMPLE_W-1:0];
   endfunction

   // One accepted word: read the tap, write the feedback sum, return the mix.
   function automatic stereo_frame_type echo_step(input stereo_frame_type x);
      stereo_frame_type y;
      int     fb;
      int     wet;
      int     tap;
      longint dl;
      longint dr;
      if (cfg_mix == 0 || cfg_delay == 0)
         return x;
      fb  = (cfg_feedback > sfd_pkg::FB_CAP) ? int'(sfd_pkg::FB_CAP) : int'(cfg_feedback);
      wet = (cfg_mix > sfd_pkg::UNITY) ? int'(sfd_pkg::UNITY) : int'(cfg_mix);
      tap = (echo_wr_pos + ECHO_DEPTH - int'(cfg_delay)) % ECHO_DEPTH;
      dl  = left_echo[tap];
      dr  = right_echo[tap];
      left_echo[echo_wr_pos]  = round_sat(longint'(x.left) * int'(sfd_pkg::UNITY) + dl * fb);
      right_echo[echo_wr_pos] = round_sat(longint'(x.right) * int'(sfd_pkg::UNITY) + dr * fb);
      y.left  = round_sat(longint'(x.left) * (int'(sfd_pkg::UNITY) - wet) + dl * wet);
      y.right = round_sat(longint'(x.right) * (int'(sfd_pkg::UNITY) - wet) + dr * wet);
      echo_wr_pos = (echo_wr_pos + 1) % ECHO_DEPTH;
      return y;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      mismatches++;
   endtask

   // ------------------------------------------------------------------
   // Driver: bursts of random length with random gaps. Hold valid and the
   // payload until the word is taken; predict each word as it is taken.
   // ------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      stereo_frame_type w;
      stereo_frame_type taken;
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         if (req_valid && req_ready) begin
            taken.left  = req_left_in;
            taken.right = req_right_in;
            mixed_due.insert(mixed_due.size(), echo_step(taken));
         end
         // advance only when the slot is free after this edge
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (frames_to_send.size() != 0) begin
               w = frames_to_send.pop_front();
               req_valid    <= 1'b1;
               req_left_in  <= w.left;
               req_right_in <= w.right;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left   <= (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: ready pattern per phase, plus one long hold-off on request
   // while the sender keeps offering, so the pipe fills and stalls req_.
   // ------------------------------------------------------------------
   int hold_count = 0;
   int rx_tick    = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         hold_count <= 0;
         hold_done  <= 1'b0;
         rx_tick    <= 0;
      end else begin
         rx_tick <= (rx_tick == 6) ? 0 : rx_tick + 1;
         if (hold_req && !hold_done) begin
            rsp_ready <= 1'b0;
            if (hold_count == HOLD_CYCLES)
               hold_done <= 1'b1;
            else
               hold_count <= hold_count + 1;
         end else begin
            case (rx_mode)
               RX_ALWAYS:  rsp_ready <= 1'b1;
               RX_RANDOM:  rsp_ready <= ($urandom_range(0, 9) < 7);
               RX_PATTERN: rsp_ready <= (rx_tick < 3);
               default:    rsp_ready <= 1'b1;
            endcase
         end
      end
   end

   // Monitor: compare every taken result word with the oldest prediction.
   always @(posedge clock) begin
      stereo_frame_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (mixed_due.size() == 0) begin
            flag_mismatch($sformatf("result word (%0d, %0d) with nothing expected",
                                    rsp_left_out, rsp_right_out));
         end else begin
            want = mixed_due.pop_front();
            if (rsp_left_out !== want.left)
               flag_mismatch($sformatf("left_out got %0d expected %0d",
                                       rsp_left_out, want.left));
            if (rsp_right_out !== want.right)
               flag_mismatch($sformatf("right_out got %0d expected %0d",
                                       rsp_right_out, want.right));
         end
      end
   end

   // Hard stop in case the block hangs.
   int cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("stereo_feedback_delay_unit_tb failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sequencing helpers
   // ------------------------------------------------------------------

   // APB write (setup, access), then read back known registers.
   task automatic write_register(input sfd_pkg::reg_index_type idx, input logic [31:0] data);
      logic [31:0] readback;
      logic [31:0] want;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         sfd_pkg::REG_DELAY: begin
            cfg_delay = data[sfd_pkg::DLY_BITS-1:0];
            want = 32'(cfg_delay);
         end
         sfd_pkg::REG_FEEDBACK: begin
            cfg_feedback = data[sfd_pkg::GAIN_BITS-1:0];
            want = 32'(cfg_feedback);
         end
         sfd_pkg::REG_MIX: begin
            cfg_mix = data[sfd_pkg::MIX_BITS-1:0];
            want = 32'(cfg_mix);
         end
         default: return;   // no register there: drop the write, skip readback
      endcase
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== want)
         flag_mismatch($sformatf("register %0d read %0h expected %0h", idx, readback, want));
   endtask

   // Set all three registers; junk in the unused upper bits must be dropped.
   task automatic set_echo(input int dly, input int fb, input int mix);
      write_register(sfd_pkg::REG_DELAY,    ($urandom & ~32'h1FFFF) | 32'(dly));
      write_register(sfd_pkg::REG_FEEDBACK, ($urandom & ~32'hFFFF)  | 32'(fb));
      write_register(sfd_pkg::REG_MIX,      ($urandom & ~32'h1FFFF) | 32'(mix));
   endtask

   // Wait until every word is sent and every prediction is matched, then let the pipe settle.
   task automatic drain;
      while (frames_to_send.size() != 0 || mixed_due.size() != 0 || req_valid)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic void push_frame(input int l, input int r);
      stereo_frame_type f;
      f.left  = l[SAMPLE_W-1:0];
      f.right = r[SAMPLE_W-1:0];
      frames_to_send.insert(frames_to_send.size(), f);
   endfunction

   // Mix of full-range noise, full-scale peaks and quiet material.
   function automatic int random_sample;
      case ($urandom_range(0, 9))
         0:       return 32767;
         1:       return -32768;
         2, 3:    return $urandom_range(0, 511) - 256;
         default: return $signed(16'($urandom));
      endcase
   endfunction

   task automatic pick_random_echo;
      int dly;
      int fb;
      int mix;
      case ($urandom_range(0, 9))
         0:       dly = 0;
         1:       dly = 1;
         2:       dly = ECHO_DEPTH - 1;
         3, 4:    dly = $urandom_range(100, 1500);   // reach words from earlier phases
         default: dly = $urandom_range(2, 64);
      endcase
      case ($urandom_range(0, 7))
         0:       fb = 0;
         1:       fb = sfd_pkg::FB_CAP;
         2:       fb = 65535;
         3:       fb = $urandom_range(int'(sfd_pkg::FB_CAP) + 1, 65535);
         default: fb = $urandom_range(0, 65535);
      endcase
      case ($urandom_range(0, 9))
         0:       mix = 0;
         1:       mix = sfd_pkg::UNITY;
         2:       mix = $urandom_range(int'(sfd_pkg::UNITY) + 1, 131071);
         3:       mix = 1;
         default: mix = $urandom_range(1, 65535);
      endcase
      set_echo(dly, fb, mix);
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset settings bypass: extremes pass straight through.
      @(posedge clock);
      push_frame(32767, -32768);
      push_frame(-32768, 32767);
      push_frame(0, -1);
      push_frame(1, 0);
      drain();

      // One-sample delay, feedback above the cap, fully wet: full-scale
      // words drive the feedback into saturation, then let it ring out.
      set_echo(1, 65535, sfd_pkg::UNITY);
      repeat (8) push_frame(32767, -32768);
      repeat (2) push_frame(0, 0);
      repeat (2) push_frame(-32768, 32767);
      drain();

      // Mix above one acts as fully wet; feedback exactly at the cap.
      // A write to the empty register slot must change nothing.
      set_echo(3, sfd_pkg::FB_CAP, 131071);
      write_register(REG_UNUSED, $urandom);
      push_frame(32767, 32767);
      push_frame(-32768, -32768);
      push_frame(-1, 1);
      push_frame(12345, -12345);
      push_frame(0, 0);
      drain();

      // Random phases: new settings each time, random words, varied idling.
      // The hold-off phase sends with no gaps so the pipe fills.
      for (int p = 0; p < PHASES; p++) begin
         pick_random_echo();
         gap_max <= (p % 3 == 0 || p == 4) ? 0 : $urandom_range(1, 12);
         rx_mode <= rx_mode_type'(p % 3);
         for (int i = 0; i < PHASE_WORDS; i++)
            push_frame(random_sample(), random_sample());
         if (p == 4) begin
            // hold the receiver off while the sender keeps offering words
            hold_req <= 1'b1;
            while (!hold_done) @(posedge clock);
            hold_req <= 1'b0;
         end
         drain();
      end

      if (mismatches == 0)
         $display("stereo_feedback_delay_unit_tb passed");
      else
         $display("stereo_feedback_delay_unit_tb failed");
      $finish;
   end

endmodule

FILE: stereo_feedback_delay_unit.f
sv/sfd_pkg.sv
sv/sfd_ram.sv
sv/sfd_mac.sv
sv/stereo_feedback_delay_unit.sv
test/stereo_feedback_delay_unit_tb.sv
